@@ hdl/lfuda_cache_replacement_macros.svh @@
// Assertion macros for the LFUDA cache directory checker.
// Included by the checker file only.
`ifndef LFUDA_CACHE_REPLACEMENT_MACROS_SVH
`define LFUDA_CACHE_REPLACEMENT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define LFUDA_ASSERT_IMP(label, clk, rst_n, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
    else $error(msg);
// Next-cycle implication outside reset.
`define LFUDA_ASSERT_NXT(label, clk, rst_n, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error(msg);
`endif

@@ hdl/lfuda_pkg.sv @@
// Package for the LFUDA cache directory: sizes, status codes, command structs.
// No dependencies.
`default_nettype none
package lfuda_pkg;
  localparam int ENTRIES       = 64;
  localparam int PRIORITY_BITS = 32;
  localparam int IDX_BITS      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_BITS      = $clog2(ENTRIES + 1);
  localparam int RESULT_LIMIT  = 64;
  localparam logic [PRIORITY_BITS-1:0] PRIO_MAX = {PRIORITY_BITS{1'b1}};

  localparam logic [2:0] ST_MISS    = 3'd0;
  localparam logic [2:0] ST_HIT     = 3'd1;
  localparam logic [2:0] ST_EVICT   = 3'd2;
  localparam logic [2:0] ST_INSERT  = 3'd3;
  localparam logic [2:0] ST_REJECT  = 3'd4;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;      // capture input transaction, reset scan
    logic scan;      // examine entry at scan index
    logic evict;     // evict current victim
    logic raise;     // raise hit entry
    logic insert;    // write new entry into free slot
    logic emit;      // load output register
    logic [2:0] status;
    logic last;
  } lfuda_cmd_t;

  // Status back to controller
  typedef struct packed {
    logic scan_done;
    logic hit_found;
    logic kind;
    logic too_big;
    logic need_evict;  // no fit or no free slot
    logic victim_found;
    logic budget_left;
  } lfuda_sts_t;
endpackage
`default_nettype wire

@@ hdl/lfuda_datapath.sv @@
// Datapath of the LFUDA directory: entry registers, scan unit, counters.
// Depends on lfuda_pkg.
`default_nettype none
module lfuda_datapath (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_write,
  input  wire logic [31:0]           cfg_data,
  input  wire logic                  in_kind,
  input  wire logic [31:0]           in_segment_key,
  input  wire logic [23:0]           in_segment_size,
  input  wire lfuda_pkg::lfuda_cmd_t cmd,
  output lfuda_pkg::lfuda_sts_t      sts,
  output logic [2:0]                 res_status,
  output logic [31:0]                res_key,
  output logic [31:0]                res_used,
  output logic                       res_last
);
  localparam int N  = lfuda_pkg::ENTRIES;
  localparam int IB = lfuda_pkg::IDX_BITS;
  localparam int CB = lfuda_pkg::CNT_BITS;
  localparam int PB = lfuda_pkg::PRIORITY_BITS;

  logic [N-1:0]  valid_r;
  logic [31:0]   ekey_r  [N];
  logic [23:0]   esize_r [N];
  logic [PB-1:0] eprio_r [N];
  logic [PB-1:0] ehits_r [N];
  logic [PB-1:0] age_r;
  logic [31:0]   occ_r, cap_r;
  logic          kind_r;
  logic [31:0]   key_r;
  logic [23:0]   size_r;
  logic [CB-1:0] scan_r;
  logic [IB-1:0] idx;
  logic          hit_r, vic_r, free_r;
  logic [IB-1:0] hit_idx_r, vic_idx_r, free_idx_r;
  logic [5:0]    nev_r;
  logic          rd_v_r, rd_ent_r;
  logic [IB-1:0] rd_idx_r;
  logic [31:0]   rd_key_r;
  logic [23:0]   rd_size_r;
  logic [PB-1:0] rd_prio_r, rd_hits_r;
  logic [PB-1:0] hit_hits_r, vic_prio_r;
  logic [31:0]   vic_key_r;
  logic [23:0]   vic_size_r;

  assign idx = scan_r[IB-1:0];

  function automatic logic [PB-1:0] sat_inc(input logic [PB-1:0] a, input logic [PB-1:0] b);
    logic [PB:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[PB] ? lfuda_pkg::PRIO_MAX : s[PB-1:0];
  endfunction

  logic [32:0] need;
  assign need = {1'b0, occ_r} + {9'd0, size_r};

  assign sts.scan_done    = (scan_r == CB'(N));
  assign sts.hit_found    = hit_r;
  assign sts.kind         = kind_r;
  assign sts.too_big      = {8'd0, size_r} > cap_r;
  assign sts.need_evict   = (need > {1'b0, cap_r}) || !free_r;
  assign sts.victim_found = vic_r;
  assign sts.budget_left  = nev_r < 6'(lfuda_pkg::RESULT_LIMIT - 1);

  // Capacity register
  always_ff @(posedge clk) begin
    if (!rst_n) cap_r <= '0;
    else if (cfg_write) cap_r <= cfg_data;
  end

  // Capture transaction, read one entry per cycle, evaluate the entry read last cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_r <= '0; hit_r <= 1'b0; vic_r <= 1'b0; free_r <= 1'b0; nev_r <= '0;
      rd_v_r <= 1'b0;
    end else begin
      rd_v_r <= cmd.scan;
      if (cmd.load) begin
        kind_r <= in_kind; key_r <= in_segment_key; size_r <= in_segment_size;
        scan_r <= '0; hit_r <= 1'b0; vic_r <= 1'b0; free_r <= 1'b0; nev_r <= '0;
      end else if (cmd.evict) begin
        scan_r <= '0; vic_r <= 1'b0; free_r <= 1'b0;
        nev_r <= nev_r + 6'd1;
      end else begin
        if (cmd.scan) begin
          scan_r    <= scan_r + CB'(1);
          rd_idx_r  <= idx;
          rd_ent_r  <= valid_r[idx];
          rd_key_r  <= ekey_r[idx];
          rd_size_r <= esize_r[idx];
          rd_prio_r <= eprio_r[idx];
          rd_hits_r <= ehits_r[idx];
        end
        if (rd_v_r) begin
          if (rd_ent_r) begin
            if (rd_key_r == key_r && !hit_r) begin
              hit_r <= 1'b1; hit_idx_r <= rd_idx_r; hit_hits_r <= rd_hits_r;
            end
            if (!vic_r || rd_prio_r < vic_prio_r ||
                (rd_prio_r == vic_prio_r && rd_key_r < vic_key_r)) begin
              vic_r <= 1'b1; vic_idx_r <= rd_idx_r; vic_prio_r <= rd_prio_r;
              vic_key_r <= rd_key_r; vic_size_r <= rd_size_r;
            end
          end else if (!free_r) begin
            free_r <= 1'b1; free_idx_r <= rd_idx_r;
          end
        end
      end
    end
  end

  // Entry updates, age and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0; age_r <= '0; occ_r <= '0;
    end else if (cmd.evict) begin
      valid_r[vic_idx_r] <= 1'b0;
      age_r <= vic_prio_r;
      occ_r <= occ_r - {8'd0, vic_size_r};
    end else if (cmd.raise) begin
      ehits_r[hit_idx_r] <= sat_inc(hit_hits_r, PB'(1));
      eprio_r[hit_idx_r] <= sat_inc(age_r, sat_inc(hit_hits_r, PB'(1)));
    end else if (cmd.insert) begin
      valid_r[free_idx_r] <= 1'b1;
      ekey_r[free_idx_r]  <= key_r;
      esize_r[free_idx_r] <= size_r;
      ehits_r[free_idx_r] <= PB'(1);
      eprio_r[free_idx_r] <= sat_inc(age_r, PB'(1));
      occ_r <= need[31:0];
    end
  end

  // Result fields; used_size reflects updates of this cycle
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      res_status <= cmd.status;
      res_last   <= cmd.last;
      res_key    <= cmd.evict ? vic_key_r : key_r;
      res_used   <= cmd.evict ? occ_r - {8'd0, vic_size_r} :
                    cmd.insert ? need[31:0] : occ_r;
    end
  end
endmodule
`default_nettype wire

@@ hdl/lfuda_ctrl.sv @@
// Controller state machine of the LFUDA directory.
// Depends on lfuda_pkg.
`default_nettype none
module lfuda_ctrl (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  input  wire lfuda_pkg::lfuda_sts_t sts,
  output lfuda_pkg::lfuda_cmd_t      cmd
);
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_DEC  = 2'd2;
  localparam logic [1:0] S_OUT  = 2'd3;

  logic [1:0] state_r, state_nxt;
  logic       ov_r, ov_nxt, fin_r, fin_nxt;
  logic       slot_free;

  assign slot_free = !ov_r || !out_stall;
  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = ov_r;

  always_comb begin
    cmd = '0;
    state_nxt = state_r;
    fin_nxt = fin_r;
    ov_nxt = ov_r && out_stall;
    case (state_r)
      S_IDLE: if (in_valid) begin
        cmd.load = 1'b1; state_nxt = S_SCAN; fin_nxt = 1'b0;
      end
      S_SCAN: begin
        if (sts.scan_done) state_nxt = S_DEC;
        else cmd.scan = 1'b1;
      end
      S_DEC: if (slot_free) begin
        cmd.emit = 1'b1; ov_nxt = 1'b1; cmd.last = 1'b1;
        state_nxt = S_OUT; fin_nxt = 1'b1;
        if (sts.hit_found) begin
          cmd.raise = 1'b1; cmd.status = lfuda_pkg::ST_HIT;
        end else if (!sts.kind) begin
          cmd.status = lfuda_pkg::ST_MISS;
        end else if (sts.too_big) begin
          cmd.status = lfuda_pkg::ST_REJECT;
        end else if (sts.need_evict && sts.victim_found && sts.budget_left) begin
          cmd.evict = 1'b1; cmd.status = lfuda_pkg::ST_EVICT; cmd.last = 1'b0;
          fin_nxt = 1'b0;
        end else if (sts.need_evict) begin
          cmd.status = lfuda_pkg::ST_REJECT;
        end else begin
          cmd.insert = 1'b1; cmd.status = lfuda_pkg::ST_INSERT;
        end
      end
      S_OUT: state_nxt = fin_r ? S_IDLE : S_SCAN;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; ov_r <= 1'b0; fin_r <= 1'b0;
    end else begin
      state_r <= state_nxt; ov_r <= ov_nxt; fin_r <= fin_nxt;
    end
  end
endmodule
`default_nettype wire

@@ hdl/lfuda_cache_replacement.sv @@
// LFUDA cache directory, top level: joins controller and datapath.
// Depends on lfuda_pkg, lfuda_ctrl, lfuda_datapath.
//
// Use: present a request on in_* with in_valid; it is taken when in_stall
// is low. Lookups (kind 0) return hit or miss; inserts (kind 1) return hit, or one
// evicted-entry transaction per eviction, then insert or reject with last=1.
// Each result scans all ENTRIES slots one per cycle, then passes a decision
// state, which waits while the output register is full and stalled, and an
// output state; no new request is taken until the item's last result is made.
// Results sit in an output register; while out_stall is high the register
// holds and the controller waits before producing the next result.
// cfg_write loads capacity; write it only while idle.
// Synchronous active-low reset clears all valid bits, age, occupancy and
// capacity; the block is ready the cycle after reset drops.
`default_nettype none
module lfuda_cache_replacement (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_write,
  input  wire logic [31:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_kind,
  input  wire logic [31:0] in_segment_key,
  input  wire logic [23:0] in_segment_size,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       out_status,
  output logic [31:0]      out_item_key,
  output logic [31:0]      out_used_size,
  output logic             out_last
);
  lfuda_pkg::lfuda_cmd_t cmd;
  lfuda_pkg::lfuda_sts_t sts;

  lfuda_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_stall, .out_valid, .out_stall, .sts, .cmd
  );

  lfuda_datapath u_dp (
    .clk, .rst_n, .cfg_write, .cfg_data, .in_kind, .in_segment_key,
    .in_segment_size, .cmd, .sts,
    .res_status(out_status), .res_key(out_item_key),
    .res_used(out_used_size), .res_last(out_last)
  );
endmodule
`default_nettype wire

@@ hdl/lfuda_checker.sv @@
// Port-level checker for the LFUDA directory, bound to the top level.
// Depends on lfuda_cache_replacement_macros.svh and lfuda_pkg.
`default_nettype none
`include "lfuda_cache_replacement_macros.svh"
module lfuda_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [2:0]  out_status,
  input wire logic [31:0] out_item_key,
  input wire logic        out_last
);
  // Only evictions are non-final results
  `LFUDA_ASSERT_IMP(a_last_kind, clk, rst_n, out_valid && !out_last, out_status == lfuda_pkg::ST_EVICT, "non-final result is not an eviction")
  // Status codes stay in range
  `LFUDA_ASSERT_IMP(a_status_rng, clk, rst_n, out_valid, out_status <= lfuda_pkg::ST_REJECT, "status out of range")
  // Accepting input means the block is idle; after an accept it blocks further input
  `LFUDA_ASSERT_NXT(a_busy, clk, rst_n, in_valid && !in_stall, in_stall, "input not blocked after accept")
  // Stalled result holds
  `LFUDA_ASSERT_NXT(a_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_item_key), "stalled result changed")
endmodule
bind lfuda_cache_replacement lfuda_checker u_chk (.*);
`default_nettype wire

@@ bench/lfuda_checker.sv @@
// Checker for the LFUDA cache directory: watches the channels, predicts and compares.
// Depends on lfuda_pkg for the status codes and the directory size.
module lfuda_tb_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_write,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic        in_kind,
  input  logic [31:0] in_segment_key,
  input  logic [23:0] in_segment_size,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [2:0]  out_status,
  input  logic [31:0] out_item_key,
  input  logic [31:0] out_used_size,
  input  logic        out_last,
  output int          errors,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PBITS = lfuda_pkg::PRIORITY_BITS;
  localparam int NENT  = lfuda_pkg::ENTRIES;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] key;
    logic [31:0] used;
    logic        last;
  } cache_result_t;

  localparam int EVICT_BUDGET = lfuda_pkg::RESULT_LIMIT - 1;

  cache_result_t expected_results[$];
  logic             dir_valid [NENT];
  logic [31:0]      dir_key   [NENT];
  logic [23:0]      dir_size  [NENT];
  logic [PBITS-1:0] dir_prio  [NENT];
  logic [PBITS-1:0] dir_hits  [NENT];
  logic [PBITS-1:0] age;
  logic [33:0]      occupied;
  logic [31:0]      capacity;
  int               err_count;

  assign errors  = err_count;
  assign pending = expected_results.size();

  function automatic logic [PBITS-1:0] sat_inc(logic [PBITS-1:0] a, logic [PBITS-1:0] b);
    logic [PBITS:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[PBITS] ? lfuda_pkg::PRIO_MAX : s[PBITS-1:0];
  endfunction

  task automatic push_result(logic [2:0] st, logic [31:0] key, logic last);
    cache_result_t r;
    r.status = st;
    r.key    = key;
    r.used   = occupied[31:0];
    r.last   = last;
    expected_results.push_back(r);
  endtask

  function automatic int free_slot();
    for (int i = 0; i < NENT; i++) if (!dir_valid[i]) return i;
    return -1;
  endfunction

  // Work out every result of one request and update the directory copy.
  task automatic predict_request(logic kind, logic [31:0] key, logic [23:0] size);
    int hit;
    int n;
    int victim;
    int slot;
    hit = -1;
    n = 0;
    for (int i = 0; i < NENT; i++)
      if (hit < 0 && dir_valid[i] && dir_key[i] == key) hit = i;
    if (hit >= 0) begin
      dir_hits[hit] = sat_inc(dir_hits[hit], PBITS'(1));
      dir_prio[hit] = sat_inc(age, dir_hits[hit]);
      push_result(lfuda_pkg::ST_HIT, key, 1'b1);
      return;
    end
    if (!kind) begin
      push_result(lfuda_pkg::ST_MISS, key, 1'b1);
      return;
    end
    if (size > capacity) begin
      push_result(lfuda_pkg::ST_REJECT, key, 1'b1);
      return;
    end
    // Evict minimum priority, lowest key on ties, until it fits and a slot frees, or the eviction budget runs out.
    while ((occupied + size > capacity || free_slot() < 0) && n < EVICT_BUDGET) begin
      victim = -1;
      for (int i = 0; i < NENT; i++) begin
        if (dir_valid[i] && (victim < 0 || dir_prio[i] < dir_prio[victim] ||
            (dir_prio[i] == dir_prio[victim] && dir_key[i] < dir_key[victim])))
          victim = i;
      end
      if (victim < 0) break;
      age = dir_prio[victim];
      occupied = occupied - dir_size[victim];
      dir_valid[victim] = 1'b0;
      push_result(lfuda_pkg::ST_EVICT, dir_key[victim], 1'b0);
      n++;
    end
    slot = free_slot();
    if (occupied + size > capacity || slot < 0) begin
      push_result(lfuda_pkg::ST_REJECT, key, 1'b1);
      return;
    end
    dir_valid[slot] = 1'b1;
    dir_key[slot]   = key;
    dir_size[slot]  = size;
    dir_hits[slot]  = PBITS'(1);
    dir_prio[slot]  = sat_inc(age, PBITS'(1));
    occupied = occupied + size;
    push_result(lfuda_pkg::ST_INSERT, key, 1'b1);
  endtask

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got 0x%08h, want 0x%08h at %0t", what, got, want, $realtime);
    err_count++;
  endtask

  initial err_count = 0;

  // Track configuration, predict accepted requests, compare accepted results.
  always @(posedge clk) begin
    cache_result_t want;
    if (!rst_n) begin
      for (int i = 0; i < NENT; i++) dir_valid[i] = 1'b0;
      age = '0;
      occupied = '0;
      capacity = '0;
      expected_results.delete();
    end else begin
      if (cfg_write) capacity = cfg_data;
      if (in_valid && !in_stall) predict_request(in_kind, in_segment_key, in_segment_size);
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result key", out_item_key, '0);
        end else begin
          want = expected_results.pop_front();
          if (out_status != want.status) report_mismatch("status", out_status, want.status);
          if (out_item_key != want.key) report_mismatch("item_key", out_item_key, want.key);
          if (out_used_size != want.used) report_mismatch("used_size", out_used_size, want.used);
          if (out_last != want.last) report_mismatch("last", out_last, want.last);
        end
      end
    end
  end
endmodule

@@ bench/tb.sv @@
// Top of the LFUDA cache directory testbench: clock, reset, stimulus, verdict.
// Depends on lfuda_pkg, lfuda_cache_replacement and lfuda_tb_checker.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int SETTLE      = 80;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_write = 1'b0;
  logic [31:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_kind = 1'b0;
  logic [31:0] in_segment_key = '0;
  logic [23:0] in_segment_size = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  out_status;
  logic [31:0] out_item_key;
  logic [31:0] out_used_size;
  logic        out_last;
  int          errors;
  int          pending;
  int          cycles = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          hold_request = 0;
  int          hold_left = 0;
  logic [31:0] cur_capacity = '0;
  logic [31:0] key_pool [20];

  lfuda_cache_replacement dut (.*);
  lfuda_tb_checker chk (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // End the run if it hangs.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Drive receiver stall: long hold-off when asked, else random.
  always @(posedge clk) begin
    if (hold_request > 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) hold_left--;
    out_stall <= (hold_left > 0) || ($urandom_range(99) < recv_stall_pct);
  end

  task automatic send_request(logic kind, logic [31:0] key, logic [23:0] size);
    in_valid        <= 1'b1;
    in_kind         <= kind;
    in_segment_key  <= key;
    in_segment_size <= size;
    do @(posedge clk); while (in_stall);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
  endtask

  // Hold off until every expected transaction has come and the block is idle.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_capacity(logic [31:0] value);
    drain();
    cfg_write <= 1'b1;
    cfg_data  <= value;
    cur_capacity = value;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  function automatic logic [23:0] pick_size();
    logic [31:0] top;
    if ($urandom_range(9) == 0) return 24'($urandom);
    top = cur_capacity / 3;
    if (top > 32'hFF_FFFF) top = 32'hFF_FFFF;
    return 24'($urandom_range(top, 0));
  endfunction

  function automatic logic [31:0] pick_key();
    if ($urandom_range(9) == 0) return $urandom;
    return key_pool[$urandom_range(19)];
  endfunction

  initial begin
    logic [31:0] k;
    for (int i = 0; i < 20; i++) key_pool[i] = (i < 18) ? $urandom_range(40) : $urandom;
    key_pool[19] = 32'hFFFF_FFFF;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Zero capacity: miss, zero-size insert, oversized reject, hits.
    write_capacity(32'd0);
    send_request(1'b0, 32'd0, 24'd0);
    send_request(1'b1, 32'd0, 24'd0);
    send_request(1'b1, 32'hFFFF_FFFF, 24'd1);
    send_request(1'b0, 32'd0, 24'hFF_FFFF);
    send_request(1'b1, 32'd0, 24'd5);

    // Small capacity: evictions on size, ties on key, rejects.
    write_capacity(32'd100);
    send_request(1'b1, 32'd7, 24'd60);
    send_request(1'b1, 32'd3, 24'd40);
    send_request(1'b1, 32'd9, 24'd50);
    send_request(1'b1, 32'd11, 24'hFF_FFFF);
    send_request(1'b0, 32'd9, 24'd0);
    send_request(1'b0, 32'd9, 24'd0);
    send_request(1'b1, 32'd2, 24'd50);
    send_request(1'b1, 32'd4, 24'd100);

    // Full capacity: fill every slot, then evict for a free slot.
    write_capacity(32'hFFFF_FFFF);
    for (int i = 0; i < 64; i++) send_request(1'b1, 32'd1000 + i, 24'hFF_FFFF);
    send_request(1'b1, 32'hFFFF_FFFE, 24'hAA_AAAA);

    // Capacity lowered under a full directory: eviction budget runs out.
    write_capacity(32'd0);
    send_request(1'b1, 32'd5, 24'd0);
    send_request(1'b1, 32'd6, 24'd0);

    // Random phases over the idling modes.
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 78; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 78; end
        default: begin send_idle_pct = 20; recv_stall_pct = 20; end
      endcase
      case ($urandom_range(3))
        0: write_capacity($urandom_range(2000, 1));
        1: write_capacity(32'hFFFF_FFFF);
        2: write_capacity($urandom);
        default: write_capacity(32'd1000);
      endcase
      if (phase == 0) hold_request = 3000;
      for (int n = 0; n < 25; n++) begin
        k = pick_key();
        if ($urandom_range(9) < 7) begin
          send_request(1'b0, k, 24'($urandom));
          send_request(1'b1, k, pick_size());
        end else begin
          send_request(1'($urandom_range(1)), k, pick_size());
        end
      end
    end

    drain();
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
